// ===== rtl/tcw_pkg.sv =====
// Shared constants, codes, types and helpers for the congestion window controller.
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int FRAC_BITS   = 8;
    localparam int WINDOW_BITS = 24;

    localparam int ACK_BITS   = 31;
    localparam int DUP_BITS   = 8;
    localparam int EVT_BITS   = 32;
    localparam int PHASE_BITS = 2;
    localparam int NOTE_BITS  = 4;
    localparam int FUNC_BITS  = 2;
    localparam int ALG_BITS   = 2;
    localparam int SSTH_BITS  = 24;
    localparam int DTHR_BITS  = 4;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 24;

    localparam int DIVD_BITS = 2 * FRAC_BITS + 1;
    localparam int QSUM_BITS = (WINDOW_BITS > DIVD_BITS) ? WINDOW_BITS : DIVD_BITS;
    localparam int SUM_BITS  = QSUM_BITS + 1;
    localparam int DIV_CNT_BITS = $clog2(DIVD_BITS + 1);

    localparam int IN_TDATA_BITS  = ((ACK_BITS + 7) / 8) * 8;
    localparam int OUT_RAW_BITS   = 2 * WINDOW_BITS + PHASE_BITS + DUP_BITS + EVT_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

    localparam longint unsigned WMAX_L  = (64'd1 << WINDOW_BITS) - 64'd1;
    localparam longint unsigned ONE_L   = 64'd1 << FRAC_BITS;
    localparam longint unsigned TWO_L   = 64'd2 << FRAC_BITS;
    localparam longint unsigned THREE_L = 64'd3 << FRAC_BITS;

    localparam logic [WINDOW_BITS-1:0] WMAX   = WINDOW_BITS'(WMAX_L);
    localparam logic [WINDOW_BITS-1:0] ONE_FX = WINDOW_BITS'((ONE_L > WMAX_L) ? WMAX_L : ONE_L);
    localparam logic [WINDOW_BITS-1:0] TWO_FX = WINDOW_BITS'((TWO_L > WMAX_L) ? WMAX_L : TWO_L);
    localparam logic [QSUM_BITS-1:0]   ONE_Q   = QSUM_BITS'(ONE_L);
    localparam logic [QSUM_BITS-1:0]   THREE_Q = QSUM_BITS'(THREE_L);

    localparam logic [FUNC_BITS-1:0] FUNC_ACK     = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_DUP     = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_TIMEOUT = 2'd2;

    localparam logic [ALG_BITS-1:0] MODE_TAHOE   = 2'd0;
    localparam logic [ALG_BITS-1:0] MODE_RENO    = 2'd1;
    localparam logic [ALG_BITS-1:0] MODE_NEWRENO = 2'd2;

    localparam logic [PHASE_BITS-1:0] PHASE_SS = 2'd0;
    localparam logic [PHASE_BITS-1:0] PHASE_CA = 2'd1;
    localparam logic [PHASE_BITS-1:0] PHASE_FR = 2'd2;

    localparam logic [NOTE_BITS-1:0] NOTE_SS_INC     = 4'd0;
    localparam logic [NOTE_BITS-1:0] NOTE_AI         = 4'd1;
    localparam logic [NOTE_BITS-1:0] NOTE_EXIT_FR    = 4'd2;
    localparam logic [NOTE_BITS-1:0] NOTE_FR_INFLATE = 4'd3;
    localparam logic [NOTE_BITS-1:0] NOTE_WAIT       = 4'd4;
    localparam logic [NOTE_BITS-1:0] NOTE_TAHOE      = 4'd5;
    localparam logic [NOTE_BITS-1:0] NOTE_RENO_FR    = 4'd6;
    localparam logic [NOTE_BITS-1:0] NOTE_NEWRENO_FR = 4'd7;
    localparam logic [NOTE_BITS-1:0] NOTE_TIMEOUT    = 4'd8;
    localparam logic [NOTE_BITS-1:0] NOTE_DUP_IN_FR  = 4'd9;

    localparam logic [CFG_IDX_BITS-1:0] CFG_ALG      = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SSTHRESH = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DUP_THR  = 2'd2;

    typedef struct packed {
        logic                   start;
        logic [WINDOW_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIVD_BITS-1:0] quotient;
    } div_rsp_t;

    function automatic logic [WINDOW_BITS-1:0] sat_add(
        input logic [WINDOW_BITS-1:0] a,
        input logic [QSUM_BITS-1:0]   b
    );
        logic [SUM_BITS-1:0] s;
        s = SUM_BITS'(a) + SUM_BITS'(b);
        return (s > SUM_BITS'(WMAX)) ? WMAX : WINDOW_BITS'(s);
    endfunction

    function automatic logic [WINDOW_BITS-1:0] halve_floor(
        input logic [WINDOW_BITS-1:0] w
    );
        logic [WINDOW_BITS-1:0] h;
        h = w >> 1;
        return (h < TWO_FX) ? TWO_FX : h;
    endfunction

endpackage

// ===== rtl/tcw_div.sv =====
// Bit-serial restoring divider that forms 2^(2*FRAC_BITS) / divisor.
`timescale 1ns / 1ps

module tcw_div (
    input  logic            aclk,
    input  logic            aresetn,
    input  tcw_pkg::div_req_t req,
    output tcw_pkg::div_rsp_t rsp
);
    import tcw_pkg::*;

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [WINDOW_BITS-1:0]  rem_reg, rem_next;
    logic [WINDOW_BITS-1:0]  dvs_reg, dvs_next;
    logic [DIVD_BITS-1:0]    quo_reg, quo_next;
    logic [WINDOW_BITS:0]    trial;
    logic                    dividend_bit;

    // The dividend is a single one in its top bit, so only the first step shifts in a one.
    assign dividend_bit = (cnt_reg == DIV_CNT_BITS'(DIVD_BITS));
    assign trial        = {rem_reg, dividend_bit};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_BITS'(DIVD_BITS);
            rem_next  = '0;
            dvs_next  = req.divisor;
            quo_next  = '0;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = WINDOW_BITS'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[DIVD_BITS-2:0], 1'b1};
            end else begin
                rem_next = WINDOW_BITS'(trial);
                quo_next = {quo_reg[DIVD_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - DIV_CNT_BITS'(1);
            if (cnt_reg == DIV_CNT_BITS'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== rtl/tcp_congestion_window_fsm.sv =====
// Top level of the TCP congestion window controller: sequencer, state and stream ports.
//
//  Channel  | Direction | Handshake               | Word contents
//  ---------+-----------+-------------------------+-------------------------------------------
//  s_axis   | in        | s_axis_tvalid/tready    | tuser: func; tdata: ack_number
//  m_axis   | out       | m_axis_tvalid/tready    | tuser: note_code; tdata: window..event_index
//  cfg      | in        | cfg_wr_en               | cfg_index selects register, cfg_data value
//
// An ACK in congestion avoidance waits in ST_DIV for the bit-serial divider that forms
// the additive increase; every other event goes straight to ST_OUT.
// The result then stays on m_axis until it is taken, and s_axis_tready is low from the
// accepted word until that result is taken.
// Reset loads the window with 1.0, the threshold with 4096 (16.0 in fixed point),
// and clears phase, counters and the last ACK number.
`timescale 1ns / 1ps

module tcp_congestion_window_fsm (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [tcw_pkg::IN_TDATA_BITS-1:0]     s_axis_tdata,  // ack_number
    input  logic [tcw_pkg::FUNC_BITS-1:0]         s_axis_tuser,  // func
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // window_now, threshold_now, phase, dup_count, event_index
    output logic [tcw_pkg::OUT_TDATA_BITS-1:0]    m_axis_tdata,
    output logic [tcw_pkg::NOTE_BITS-1:0]         m_axis_tuser,  // note_code
    input  logic                                  cfg_wr_en,
    input  logic [tcw_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [tcw_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
    import tcw_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [ALG_BITS-1:0]    alg_reg;
    logic [DTHR_BITS-1:0]   dthr_reg;
    logic [WINDOW_BITS-1:0] win_reg, win_next;
    logic [WINDOW_BITS-1:0] thr_reg, thr_next;
    logic [PHASE_BITS-1:0]  phase_reg, phase_next;
    logic [DUP_BITS-1:0]    dup_reg, dup_next;
    logic [EVT_BITS-1:0]    evt_reg, evt_next;
    logic [ACK_BITS-1:0]    last_ack_reg, last_ack_next;
    logic [NOTE_BITS-1:0]   note_reg, note_next;

    logic                   accept;
    logic                   go_div;
    logic [ACK_BITS-1:0]    ack_in;
    logic [FUNC_BITS-1:0]   func_in;
    logic [WINDOW_BITS-1:0] win_inc;
    logic [WINDOW_BITS-1:0] halved;
    logic [DUP_BITS-1:0]    dup_inc;
    div_req_t               div_req;
    div_rsp_t               div_rsp;

    tcw_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign ack_in        = s_axis_tdata[ACK_BITS-1:0];
    assign func_in       = s_axis_tuser;
    assign win_inc       = sat_add(win_reg, ONE_Q);
    assign halved        = halve_floor(win_reg);
    assign dup_inc       = (dup_reg == {DUP_BITS{1'b1}}) ? dup_reg : dup_reg + DUP_BITS'(1);

    assign div_req.start   = accept && go_div;
    assign div_req.divisor = (win_reg == '0) ? WINDOW_BITS'(1) : win_reg;

    always_comb begin
        state_next    = state_reg;
        win_next      = win_reg;
        thr_next      = thr_reg;
        phase_next    = phase_reg;
        dup_next      = dup_reg;
        evt_next      = evt_reg;
        last_ack_next = last_ack_reg;
        note_next     = note_reg;
        go_div        = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    note_next  = NOTE_WAIT;
                    state_next = ST_OUT;
                    case (func_in)
                        FUNC_ACK: begin
                            evt_next      = evt_reg + EVT_BITS'(1);
                            last_ack_next = ack_in;
                            dup_next      = '0;
                            if (phase_reg == PHASE_FR) begin
                                if (ack_in > last_ack_reg) begin
                                    win_next   = thr_reg;
                                    phase_next = PHASE_CA;
                                    note_next  = NOTE_EXIT_FR;
                                end else begin
                                    win_next  = win_inc;
                                    note_next = NOTE_FR_INFLATE;
                                end
                            end else if (phase_reg == PHASE_CA) begin
                                go_div     = 1'b1;
                                note_next  = NOTE_AI;
                                state_next = ST_DIV;
                            end else begin
                                win_next  = win_inc;
                                note_next = NOTE_SS_INC;
                                if (win_inc >= thr_reg) begin
                                    phase_next = PHASE_CA;
                                end
                            end
                        end
                        FUNC_DUP: begin
                            evt_next = evt_reg + EVT_BITS'(1);
                            dup_next = dup_inc;
                            if (phase_reg == PHASE_FR) begin
                                win_next  = win_inc;
                                note_next = NOTE_DUP_IN_FR;
                            end else if (dup_inc < DUP_BITS'(dthr_reg)) begin
                                note_next = NOTE_WAIT;
                            end else begin
                                thr_next = halved;
                                if (alg_reg == MODE_TAHOE) begin
                                    win_next   = ONE_FX;
                                    phase_next = PHASE_SS;
                                    note_next  = NOTE_TAHOE;
                                end else begin
                                    win_next   = sat_add(halved, THREE_Q);
                                    phase_next = PHASE_FR;
                                    note_next  = (alg_reg == MODE_NEWRENO) ? NOTE_NEWRENO_FR
                                                                           : NOTE_RENO_FR;
                                end
                            end
                        end
                        FUNC_TIMEOUT: begin
                            evt_next   = evt_reg + EVT_BITS'(1);
                            thr_next   = halved;
                            win_next   = ONE_FX;
                            dup_next   = '0;
                            phase_next = PHASE_SS;
                            note_next  = NOTE_TIMEOUT;
                        end
                        default: begin
                            note_next = NOTE_WAIT;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    win_next   = sat_add(win_reg, QSUM_BITS'(div_rsp.quotient));
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_axis_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (cfg_wr_en && (cfg_index == CFG_SSTHRESH)) begin
            thr_next = WINDOW_BITS'(cfg_data[SSTH_BITS-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            alg_reg      <= MODE_RENO;
            dthr_reg     <= DTHR_BITS'(3);
            win_reg      <= ONE_FX;
            thr_reg      <= WINDOW_BITS'(4096);
            phase_reg    <= PHASE_SS;
            dup_reg      <= '0;
            evt_reg      <= '0;
            last_ack_reg <= '0;
            note_reg     <= NOTE_WAIT;
        end else begin
            state_reg    <= state_next;
            win_reg      <= win_next;
            thr_reg      <= thr_next;
            phase_reg    <= phase_next;
            dup_reg      <= dup_next;
            evt_reg      <= evt_next;
            last_ack_reg <= last_ack_next;
            note_reg     <= note_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_ALG: begin
                        alg_reg <= cfg_data[ALG_BITS-1:0];
                    end
                    CFG_DUP_THR: begin
                        dthr_reg <= cfg_data[DTHR_BITS-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = OUT_TDATA_BITS'({evt_reg, dup_reg, phase_reg, thr_reg, win_reg});
    assign m_axis_tuser  = note_reg;

endmodule

// ===== test/tcw_checker.sv =====
// Checker for the congestion window controller: predicts each result word and compares it.
`timescale 1ns / 1ps

module tcw_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [tcw_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,  // ack_number
    input  logic [tcw_pkg::FUNC_BITS-1:0]       s_axis_tuser,  // func
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // window_now, threshold_now, phase, dup_count, event_index
    input  logic [tcw_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,
    input  logic [tcw_pkg::NOTE_BITS-1:0]       m_axis_tuser,  // note_code
    input  logic                                cfg_wr_en,
    input  logic [tcw_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [tcw_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output int                                  errors,
    output int                                  pending
);
    import tcw_pkg::*;

    localparam int POS_THR = WINDOW_BITS;
    localparam int POS_PH  = 2 * WINDOW_BITS;
    localparam int POS_DUP = POS_PH + PHASE_BITS;
    localparam int POS_EVT = POS_DUP + DUP_BITS;

    localparam logic [WINDOW_BITS-1:0] FX_ONE   = WINDOW_BITS'(1 << FRAC_BITS);
    localparam logic [WINDOW_BITS-1:0] FX_TWO   = WINDOW_BITS'(2 << FRAC_BITS);
    localparam logic [WINDOW_BITS-1:0] FX_THREE = WINDOW_BITS'(3 << FRAC_BITS);
    localparam logic [WINDOW_BITS-1:0] FX_MAX   = '1;

    typedef struct packed {
        logic [WINDOW_BITS-1:0] window;
        logic [WINDOW_BITS-1:0] threshold;
        logic [PHASE_BITS-1:0]  phase;
        logic [DUP_BITS-1:0]    dups;
        logic [EVT_BITS-1:0]    events;
        logic [NOTE_BITS-1:0]   note;
    } cc_result_t;

    logic [ALG_BITS-1:0]    algorithm;
    logic [DTHR_BITS-1:0]   dup_limit;
    logic [WINDOW_BITS-1:0] cwnd;
    logic [WINDOW_BITS-1:0] ssthresh;
    logic [PHASE_BITS-1:0]  cc_phase;
    logic [DUP_BITS-1:0]    dup_seen;
    logic [EVT_BITS-1:0]    event_total;
    logic [ACK_BITS-1:0]    highest_ack;

    cc_result_t forecasts[$];
    cc_result_t want;
    cc_result_t got;

    function automatic logic [WINDOW_BITS-1:0] add_capped(
        input logic [WINDOW_BITS-1:0] a,
        input logic [WINDOW_BITS-1:0] b
    );
        logic [WINDOW_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WINDOW_BITS] ? FX_MAX : s[WINDOW_BITS-1:0];
    endfunction

    function automatic logic [WINDOW_BITS-1:0] halved(input logic [WINDOW_BITS-1:0] w);
        logic [WINDOW_BITS-1:0] h;
        h = w >> 1;
        if (h < FX_TWO) h = FX_TWO;
        return h;
    endfunction

    task automatic advance_window(
        input  logic [FUNC_BITS-1:0] func,
        input  logic [ACK_BITS-1:0]  ack,
        output cc_result_t           r
    );
        logic [NOTE_BITS-1:0]   note;
        logic                   fresh;
        logic [31:0]            divisor;
        logic [31:0]            increase;
        note = NOTE_WAIT;
        case (func)
            FUNC_ACK: begin
                fresh = ack > highest_ack;
                event_total = event_total + 1'b1;
                highest_ack = ack;
                dup_seen = '0;
                if (cc_phase == PHASE_FR) begin
                    if (fresh) begin
                        cwnd = ssthresh;
                        cc_phase = PHASE_CA;
                        note = NOTE_EXIT_FR;
                    end else begin
                        cwnd = add_capped(cwnd, FX_ONE);
                        note = NOTE_FR_INFLATE;
                    end
                end else if (cc_phase == PHASE_CA) begin
                    divisor = (cwnd == '0) ? 32'd1 : 32'(cwnd);
                    increase = (32'd1 << (2 * FRAC_BITS)) / divisor;
                    cwnd = add_capped(cwnd, WINDOW_BITS'(increase));
                    note = NOTE_AI;
                end else begin
                    cwnd = add_capped(cwnd, FX_ONE);
                    if (cwnd >= ssthresh) cc_phase = PHASE_CA;
                    note = NOTE_SS_INC;
                end
            end
            FUNC_DUP: begin
                event_total = event_total + 1'b1;
                if (dup_seen != '1) dup_seen = dup_seen + 1'b1;
                if (cc_phase == PHASE_FR) begin
                    cwnd = add_capped(cwnd, FX_ONE);
                    note = NOTE_DUP_IN_FR;
                end else if (dup_seen < DUP_BITS'(dup_limit)) begin
                    note = NOTE_WAIT;
                end else begin
                    ssthresh = halved(cwnd);
                    if (algorithm == MODE_TAHOE) begin
                        cwnd = FX_ONE;
                        cc_phase = PHASE_SS;
                        note = NOTE_TAHOE;
                    end else begin
                        cwnd = add_capped(ssthresh, FX_THREE);
                        cc_phase = PHASE_FR;
                        note = (algorithm == MODE_NEWRENO) ? NOTE_NEWRENO_FR : NOTE_RENO_FR;
                    end
                end
            end
            FUNC_TIMEOUT: begin
                event_total = event_total + 1'b1;
                ssthresh = halved(cwnd);
                cwnd = FX_ONE;
                dup_seen = '0;
                cc_phase = PHASE_SS;
                note = NOTE_TIMEOUT;
            end
            default: begin
            end
        endcase
        r = '{cwnd, ssthresh, cc_phase, dup_seen, event_total, note};
    endtask

    task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
        if (e !== a) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, e, a);
            errors++;
        end
    endtask

    initial errors = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            algorithm   = MODE_RENO;
            dup_limit   = 4'd3;
            cwnd        = FX_ONE;
            ssthresh    = WINDOW_BITS'(4096);
            cc_phase    = PHASE_SS;
            dup_seen    = '0;
            event_total = '0;
            highest_ack = '0;
            forecasts.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_ALG:      algorithm = cfg_data[ALG_BITS-1:0];
                    CFG_SSTHRESH: ssthresh = cfg_data[WINDOW_BITS-1:0];
                    CFG_DUP_THR:  dup_limit = cfg_data[DTHR_BITS-1:0];
                    default: begin
                    end
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tdata[0 +: WINDOW_BITS], m_axis_tdata[POS_THR +: WINDOW_BITS],
                        m_axis_tdata[POS_PH +: PHASE_BITS], m_axis_tdata[POS_DUP +: DUP_BITS],
                        m_axis_tdata[POS_EVT +: EVT_BITS], m_axis_tuser};
                if (forecasts.size() == 0) begin
                    $display("%0t: unexpected word, expected none actual %h", $time, got);
                    errors++;
                end else begin
                    want = forecasts.pop_front();
                    check_field("window_now", 32'(want.window), 32'(got.window));
                    check_field("threshold_now", 32'(want.threshold), 32'(got.threshold));
                    check_field("phase", 32'(want.phase), 32'(got.phase));
                    check_field("dup_count", 32'(want.dups), 32'(got.dups));
                    check_field("event_index", want.events, got.events);
                    check_field("note_code", 32'(want.note), 32'(got.note));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                advance_window(s_axis_tuser, s_axis_tdata[ACK_BITS-1:0], want);
                forecasts.push_back(want);
            end
        end
        pending <= forecasts.size();
    end

endmodule

// ===== test/tb_tcp_congestion_window_fsm.sv =====
// Testbench top for the congestion window controller: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_tcp_congestion_window_fsm;
    import tcw_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int ITEM_GOAL   = 1950;
    localparam int PHASE_ITEMS = 150;
    localparam logic [ALG_BITS-1:0]  MODE_UNUSED = 2'd3;
    localparam logic [FUNC_BITS-1:0] FUNC_NONE   = 2'd3;
    localparam logic [ACK_BITS-1:0]  ACK_TOP     = '1;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [IN_TDATA_BITS-1:0]    s_axis_tdata = '0;
    logic [FUNC_BITS-1:0]        s_axis_tuser = '0;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0]   m_axis_tdata;
    logic [NOTE_BITS-1:0]        m_axis_tuser;
    logic                        cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0]     cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]    cfg_data = '0;

    int errors;
    int pending;
    int cycle_count = 0;
    int sink_hold = 0;
    int hold_draw;
    int sent = 0;
    int dup_limit = 3;
    bit burst = 1'b0;
    logic [ACK_BITS-1:0] cur_ack = '0;

    tcp_congestion_window_fsm uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    tcw_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .errors        (errors),
        .pending       (pending)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_tcp_congestion_window_fsm: done, errors");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            sink_hold <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            hold_draw = burst ? 0 : $urandom_range(0, 6);
            sink_hold <= hold_draw;
            m_axis_tready <= (hold_draw == 0);
        end else if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            m_axis_tready <= (sink_hold == 1);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_word(input logic [FUNC_BITS-1:0] func, input logic [ACK_BITS-1:0] ack);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_BITS'(ack);
        s_axis_tuser  <= func;
        do @(posedge aclk); while (!s_axis_tready);
        sent++;
        if (func == FUNC_ACK) cur_ack = ack;
    endtask

    task automatic go_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int unsigned value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_BITS'(value);
        if (idx == CFG_DUP_THR) dup_limit = value;
        @(posedge aclk);
    endtask

    task automatic end_writes();
        cfg_wr_en <= 1'b0;
    endtask

    task automatic load_settings();
        int unsigned ssth;
        int unsigned dthr;
        case ($urandom_range(0, 9))
            0: ssth = 512;
            1: ssth = 24'hFFFFFF;
            2: ssth = $urandom_range(512, 24'hFFFFFF);
            default: ssth = $urandom_range(512, 8192);
        endcase
        case ($urandom_range(0, 5))
            0: dthr = 1;
            1: dthr = 15;
            default: dthr = $urandom_range(1, 6);
        endcase
        go_idle();
        write_reg(CFG_ALG, $urandom_range(0, 3));
        write_reg(CFG_SSTHRESH, ssth);
        write_reg(CFG_DUP_THR, dthr);
        end_writes();
        burst = ($urandom_range(0, 4) == 0);
    endtask

    task automatic random_traffic();
        int pick;
        int n;
        int phase_goal;
        phase_goal = sent + PHASE_ITEMS;
        while (sent < phase_goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                n = $urandom_range(1, 8);
                repeat (n) send_word(FUNC_ACK, cur_ack + ACK_BITS'($urandom_range(1, 1460)));
            end else if (pick < 75) begin
                n = $urandom_range((dup_limit > 1) ? dup_limit - 1 : 1, dup_limit + 3);
                repeat (n) send_word(FUNC_DUP, ACK_BITS'($urandom()));
            end else if (pick < 83) begin
                send_word(FUNC_ACK, cur_ack - ACK_BITS'($urandom_range(0, 3)));
            end else if (pick < 90) begin
                send_word(FUNC_TIMEOUT, ACK_BITS'($urandom()));
            end else if (pick < 95) begin
                send_word(FUNC_BITS'($urandom_range(0, 3)), ACK_BITS'($urandom()));
            end else begin
                send_word(FUNC_NONE, ACK_BITS'($urandom()));
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        send_word(FUNC_ACK, '0);
        send_word(FUNC_ACK, 31'd100);
        repeat (3) send_word(FUNC_DUP, 31'd100);
        send_word(FUNC_DUP, 31'd100);
        send_word(FUNC_ACK, 31'd100);
        send_word(FUNC_ACK, 31'd200);
        send_word(FUNC_ACK, 31'd300);
        send_word(FUNC_TIMEOUT, ACK_TOP);
        send_word(FUNC_NONE, ACK_BITS'($urandom()));
        send_word(FUNC_ACK, ACK_TOP);
        send_word(FUNC_ACK, '0);

        go_idle();
        write_reg(CFG_ALG, MODE_TAHOE);
        write_reg(CFG_DUP_THR, 1);
        end_writes();
        send_word(FUNC_DUP, '0);

        go_idle();
        write_reg(CFG_ALG, MODE_NEWRENO);
        write_reg(CFG_DUP_THR, 2);
        end_writes();
        repeat (2) send_word(FUNC_DUP, '0);
        send_word(FUNC_ACK, 31'd1000);

        go_idle();
        write_reg(CFG_ALG, MODE_UNUSED);
        write_reg(CFG_DUP_THR, 3);
        end_writes();
        repeat (3) send_word(FUNC_DUP, 31'd1000);

        go_idle();
        write_reg(CFG_SSTHRESH, 24'hFFFFFF);
        end_writes();
        send_word(FUNC_ACK, 31'd2000);
        send_word(FUNC_ACK, 31'd2001);

        go_idle();
        write_reg(CFG_SSTHRESH, 512);
        end_writes();
        send_word(FUNC_TIMEOUT, '0);

        sent = 0;
        while (sent < ITEM_GOAL) begin
            load_settings();
            random_traffic();
        end

        go_idle();
        repeat (40) @(posedge aclk);
        if (errors == 0) begin
            $display("tb_tcp_congestion_window_fsm: done, clean");
        end else begin
            $display("tb_tcp_congestion_window_fsm: done, errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/tcw_pkg.sv
rtl/tcw_div.sv
rtl/tcp_congestion_window_fsm.sv
test/tcw_checker.sv
test/tb_tcp_congestion_window_fsm.sv
